[sv/fsw_pkg.sv]
`default_nettype none
package fsw_pkg;

  localparam int GRID_DIM_DEF = 128;

  localparam logic [1:0] CELL_EMPTY = 2'd0;
  localparam logic [1:0] CELL_SAND  = 2'd1;
  localparam logic [1:0] CELL_WATER = 2'd2;

  localparam logic [1:0] KIND_TICK  = 2'd0;
  localparam logic [1:0] KIND_PAINT = 2'd1;
  localparam logic [1:0] KIND_READ  = 2'd2;

  typedef enum logic [2:0] {
    CAND_BELOW,
    CAND_BL,
    CAND_BR,
    CAND_LEFT,
    CAND_RIGHT
  } cand_t;

endpackage
`default_nettype wire

[sv/falling_sand_water_automaton_top.sv]
// Grid of GRID_DIM x GRID_DIM cells (empty, sand, water) held in one
// single-port-write RAM. After reset the block clears every RAM entry, one a
// cycle, and holds busy high meanwhile. An item is taken when start is high
// and busy is low; exactly one result follows as a one-cycle out_valid strobe
// that cannot be stalled. Paint and unknown kinds answer from S_OP, a read
// from S_RESP once the RAM data is back. A tick walks the cells bottom-up and
// right-to-left through one neighbor address unit and the RAM's single read
// port: the bottom row is skipped, each visited cell is read and then its
// neighbors are probed in turn until one allows a move, and each move writes
// the target cell and then the visited cell.
`default_nettype none
module falling_sand_water_automaton_top
  import fsw_pkg::*;
#(
  parameter int GRID_DIM = GRID_DIM_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       start,
  output logic            busy,
  input  wire logic [1:0] in_kind,
  input  wire logic [6:0] in_row,
  input  wire logic [6:0] in_col,
  input  wire logic [1:0] in_material,
  output logic            out_valid,
  output logic [1:0]      out_cell_value
);

  localparam int CW    = $clog2(GRID_DIM);
  localparam int AW    = 2 * CW;
  localparam int DEPTH = 1 << AW;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_OP,
    S_RESP,
    S_HERE,
    S_HCHK,
    S_NB,
    S_NCHK,
    S_WR_T,
    S_WR_H,
    S_ADV
  } state_t;

  state_t          state_r;
  logic [AW-1:0]   clr_r;
  logic [1:0]      kind_r;
  logic [1:0]      mat_r;
  logic            op_in_r;
  logic [AW-1:0]   op_addr_r;
  logic [CW-1:0]   r_r;
  logic [CW-1:0]   c_r;
  cand_t           cand_r;
  logic [1:0]      v_r;
  logic [1:0]      d_r;
  logic [AW-1:0]   tgt_r;
  logic            out_valid_r;
  logic [1:0]      out_val_r;

  logic            ram_we;
  logic [AW-1:0]   ram_waddr;
  logic [1:0]      ram_wdata;
  logic [AW-1:0]   ram_raddr;
  logic [1:0]      ram_rdata;

  logic            nb_ok;
  logic [AW-1:0]   nb_addr;
  logic            in_inside;
  logic            cand_last;
  logic            move;
  logic [AW-1:0]   here_addr;

  fsw_ram #(
    .WIDTH (2),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  fsw_nbr #(
    .GRID_DIM (GRID_DIM)
  ) u_nbr (
    .r    (r_r),
    .c    (c_r),
    .cand (cand_r),
    .ok   (nb_ok),
    .addr (nb_addr)
  );

  assign in_inside = (32'(in_row) < GRID_DIM) && (32'(in_col) < GRID_DIM);
  assign here_addr = {r_r, c_r};
  assign cand_last = (v_r == CELL_SAND) ? (cand_r == CAND_BR) : (cand_r == CAND_RIGHT);
  assign move      = (ram_rdata == CELL_EMPTY) ||
                     ((v_r == CELL_SAND) && (cand_r == CAND_BELOW) &&
                      (ram_rdata == CELL_WATER));

  assign busy           = (state_r != S_IDLE);
  assign out_valid      = out_valid_r;
  assign out_cell_value = out_val_r;

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = here_addr;
    ram_wdata = CELL_EMPTY;
    ram_raddr = here_addr;
    unique case (state_r)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_r;
      end
      S_OP: begin
        ram_raddr = op_addr_r;
        ram_waddr = op_addr_r;
        ram_wdata = mat_r;
        ram_we    = (kind_r == KIND_PAINT) && op_in_r &&
                    ((mat_r == CELL_SAND) || (mat_r == CELL_WATER));
      end
      S_NB: begin
        ram_raddr = nb_addr;
      end
      S_WR_T: begin
        ram_we    = 1'b1;
        ram_waddr = tgt_r;
        ram_wdata = v_r;
      end
      S_WR_H: begin
        ram_we    = 1'b1;
        ram_wdata = d_r;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
      out_val_r   <= CELL_EMPTY;
    end else begin
      out_valid_r <= 1'b0;
      unique case (state_r)
        S_CLEAR: begin
          clr_r <= clr_r + AW'(1);
          if (clr_r == AW'(DEPTH - 1)) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (start) begin
            kind_r    <= in_kind;
            mat_r     <= in_material;
            op_in_r   <= in_inside;
            op_addr_r <= {CW'(in_row), CW'(in_col)};
            state_r   <= S_OP;
          end
        end
        S_OP: begin
          priority case (kind_r)
            KIND_TICK: begin
              r_r     <= CW'(GRID_DIM - 2);
              c_r     <= CW'(GRID_DIM - 1);
              state_r <= S_HERE;
            end
            KIND_READ: begin
              state_r <= S_RESP;
            end
            default: begin
              out_valid_r <= 1'b1;
              out_val_r   <= CELL_EMPTY;
              state_r     <= S_IDLE;
            end
          endcase
        end
        S_RESP: begin
          out_valid_r <= 1'b1;
          out_val_r   <= op_in_r ? ram_rdata : CELL_EMPTY;
          state_r     <= S_IDLE;
        end
        S_HERE: begin
          state_r <= S_HCHK;
        end
        S_HCHK: begin
          v_r    <= ram_rdata;
          cand_r <= CAND_BELOW;
          if ((ram_rdata == CELL_SAND) || (ram_rdata == CELL_WATER)) begin
            state_r <= S_NB;
          end else begin
            state_r <= S_ADV;
          end
        end
        S_NB: begin
          tgt_r <= nb_addr;
          if (nb_ok) begin
            state_r <= S_NCHK;
          end else if (cand_last) begin
            state_r <= S_ADV;
          end else begin
            cand_r <= cand_t'(cand_r + 3'd1);
          end
        end
        S_NCHK: begin
          d_r <= ram_rdata;
          if (move) begin
            state_r <= S_WR_T;
          end else if (cand_last) begin
            state_r <= S_ADV;
          end else begin
            cand_r  <= cand_t'(cand_r + 3'd1);
            state_r <= S_NB;
          end
        end
        S_WR_T: begin
          state_r <= S_WR_H;
        end
        S_WR_H: begin
          state_r <= S_ADV;
        end
        S_ADV: begin
          if (c_r != '0) begin
            c_r     <= c_r - CW'(1);
            state_r <= S_HERE;
          end else if (r_r != '0) begin
            r_r     <= r_r - CW'(1);
            c_r     <= CW'(GRID_DIM - 1);
            state_r <= S_HERE;
          end else begin
            out_valid_r <= 1'b1;
            out_val_r   <= CELL_EMPTY;
            state_r     <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

[sv/fsw_ram.sv]
`default_nettype none
module fsw_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 16384
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

[sv/fsw_nbr.sv]
`default_nettype none
module fsw_nbr
  import fsw_pkg::*;
#(
  parameter int GRID_DIM = GRID_DIM_DEF,
  localparam int CW = $clog2(GRID_DIM)
) (
  input  wire logic [CW-1:0]   r,
  input  wire logic [CW-1:0]   c,
  input  wire cand_t           cand,
  output logic                 ok,
  output logic [2*CW-1:0]      addr
);

  logic [CW-1:0] tr;
  logic [CW-1:0] tc;
  logic          has_left;
  logic          has_right;

  assign has_left  = (c != '0);
  assign has_right = (c != CW'(GRID_DIM - 1));

  // target cell of the candidate move, rows below are always inside
  always_comb begin
    tr = r + CW'(1);
    tc = c;
    ok = 1'b1;
    unique case (cand)
      CAND_BELOW: begin
      end
      CAND_BL: begin
        tc = c - CW'(1);
        ok = has_left;
      end
      CAND_BR: begin
        tc = c + CW'(1);
        ok = has_right;
      end
      CAND_LEFT: begin
        tr = r;
        tc = c - CW'(1);
        ok = has_left;
      end
      CAND_RIGHT: begin
        tr = r;
        tc = c + CW'(1);
        ok = has_right;
      end
      default: begin
        ok = 1'b0;
      end
    endcase
  end

  assign addr = {tr, tc};

endmodule
`default_nettype wire
